/* rtl/mpts_pkg.sv */
package mpts_pkg;

  localparam int MAX_PROCS = 16;
  localparam int SLOT_W    = 4;
  localparam int CNT_W     = 5;
  localparam int TIME_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int POL_W     = 3;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [POL_W-1:0] POL_FCFS_SLOT = 3'd0;
  localparam logic [POL_W-1:0] POL_FCFS_ARR  = 3'd1;
  localparam logic [POL_W-1:0] POL_PRIO_PRE  = 3'd2;
  localparam logic [POL_W-1:0] POL_PRIO_NON  = 3'd3;
  localparam logic [POL_W-1:0] POL_RR        = 3'd4;
  localparam logic [POL_W-1:0] POL_SJF       = 3'd5;
  localparam logic [POL_W-1:0] POL_SRTF      = 3'd6;
  localparam logic [POL_W-1:0] POL_UNUSED    = 3'd7;

  localparam logic REG_POLICY  = 1'b0;
  localparam logic REG_QUANTUM = 1'b1;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_CLEAR,
    OP_TICK_START,
    OP_TAKE_HOLD,
    OP_SCAN_START,
    OP_SCAN_STEP,
    OP_TAKE_BEST,
    OP_POP,
    OP_CAND_CHK,
    OP_EXEC,
    OP_REQUEUE,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   admit;
    logic   drop_hold;
  } dp_cmd_t;

  typedef struct packed {
    logic hold_usable;
    logic cand_ready;
    logic scan_done;
    logic ring_empty;
    logic requeue;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/mpts_datapath.sv */
module mpts_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mpts_pkg::dp_cmd_t            cmd_i,
  output mpts_pkg::dp_status_t         status_o,
  input  logic [mpts_pkg::POL_W-1:0]   pol_i,
  input  logic [mpts_pkg::TIME_W-1:0]  quantum_i,
  input  logic [mpts_pkg::TIME_W-1:0]  arrival_time_i,
  input  logic [mpts_pkg::TIME_W-1:0]  burst_time_i,
  input  logic [mpts_pkg::PRIO_W-1:0]  priority_level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mpts_pkg::SLOT_W-1:0]  running_slot_o,
  output logic                         idle_o,
  output logic                         finished_o,
  output logic [mpts_pkg::TIME_W-1:0]  completion_time_o,
  output logic [mpts_pkg::TIME_W-1:0]  turnaround_o,
  output logic [mpts_pkg::TIME_W-1:0]  waiting_o
);
  import mpts_pkg::*;

  logic [TIME_W-1:0] arr_q [MAX_PROCS];
  logic [TIME_W-1:0] bur_q [MAX_PROCS];
  logic [TIME_W-1:0] rem_q [MAX_PROCS];
  logic [PRIO_W-1:0] pri_q [MAX_PROCS];
  logic [SLOT_W-1:0] ring_q [MAX_PROCS];

  logic [CNT_W-1:0]     count_q;
  logic [TIME_W-1:0]    time_q;
  logic [SLOT_W-1:0]    held_q;
  logic                 held_v_q;
  logic [TIME_W-1:0]    slice_q;
  logic [SLOT_W-1:0]    head_q;
  logic [CNT_W-1:0]     fill_q;
  logic [MAX_PROCS-1:0] admitted_q;
  logic [MAX_PROCS-1:0] inring_q;
  logic [CNT_W-1:0]     k_q;
  logic                 found_q;
  logic [SLOT_W-1:0]    best_q;
  logic [TIME_W-1:0]    best_key_q;
  logic [SLOT_W-1:0]    cand_q;
  logic [SLOT_W-1:0]    chosen_q;
  logic                 chosen_v_q;

  logic                 res_idle_q;
  logic                 res_fin_q;
  logic [SLOT_W-1:0]    res_slot_q;
  logic [TIME_W-1:0]    res_comp_q;
  logic [TIME_W-1:0]    res_tat_q;
  logic [TIME_W-1:0]    res_wait_q;

  logic                 out_valid_q;
  logic                 out_idle_q;
  logic                 out_fin_q;
  logic [SLOT_W-1:0]    out_slot_q;
  logic [TIME_W-1:0]    out_comp_q;
  logic [TIME_W-1:0]    out_tat_q;
  logic [TIME_W-1:0]    out_wait_q;

  logic [SLOT_W-1:0] rd_addr;
  logic [TIME_W-1:0] arr_rd;
  logic [TIME_W-1:0] bur_rd;
  logic [TIME_W-1:0] rem_rd;
  logic [PRIO_W-1:0] pri_rd;
  logic              rd_ready;
  logic [TIME_W-1:0] key;
  logic              better;
  logic              admit_ok;
  logic              push_en;
  logic [SLOT_W-1:0] push_slot;
  logic              push_ok;
  logic [CNT_W:0]    tail_sum;
  logic [SLOT_W-1:0] tail;
  logic [SLOT_W-1:0] head_next;
  logic [TIME_W-1:0] rem_new;
  logic [TIME_W-1:0] time_new;
  logic [TIME_W-1:0] slice_new;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] q_eff;
  logic              add_ok;

  always_comb begin
    case (cmd_i.op)
      OP_SCAN_STEP:     rd_addr = k_q[SLOT_W-1:0];
      OP_CAND_CHK:      rd_addr = cand_q;
      OP_EXEC:          rd_addr = chosen_q;
      OP_REQUEUE:       rd_addr = chosen_q;
      default:          rd_addr = held_q;
    endcase
  end

  assign arr_rd   = arr_q[rd_addr];
  assign bur_rd   = bur_q[rd_addr];
  assign rem_rd   = rem_q[rd_addr];
  assign pri_rd   = pri_q[rd_addr];
  assign rd_ready = ({1'b0, rd_addr} < count_q) && (arr_rd <= time_q) && (rem_rd != '0);

  always_comb begin
    case (pol_i)
      POL_FCFS_ARR: key = arr_rd;
      POL_PRIO_PRE: key = {{(TIME_W-PRIO_W){1'b0}}, pri_rd};
      POL_PRIO_NON: key = {{(TIME_W-PRIO_W){1'b0}}, pri_rd};
      POL_SJF:      key = bur_rd;
      POL_SRTF:     key = rem_rd;
      default:      key = '0;
    endcase
  end

  assign better   = rd_ready && (!found_q || key < best_key_q);
  assign admit_ok = !admitted_q[rd_addr] && rd_ready && !(held_v_q && held_q == rd_addr);

  assign push_en   = (cmd_i.op == OP_SCAN_STEP && cmd_i.admit && admit_ok) ||
                     (cmd_i.op == OP_REQUEUE);
  assign push_slot = rd_addr;
  assign push_ok   = push_en && (fill_q < CNT_W'(MAX_PROCS)) && !inring_q[push_slot];

  assign tail_sum  = {{(CNT_W+1-SLOT_W){1'b0}}, head_q} + {1'b0, fill_q};
  assign tail      = (tail_sum >= (CNT_W+1)'(MAX_PROCS)) ?
                     SLOT_W'(tail_sum - (CNT_W+1)'(MAX_PROCS)) : SLOT_W'(tail_sum);
  assign head_next = (head_q == SLOT_W'(MAX_PROCS - 1)) ? '0 : head_q + 1'b1;

  assign rem_new   = rem_rd - 1'b1;
  assign time_new  = time_q + 1'b1;
  assign slice_new = (slice_q == '1) ? slice_q : slice_q + 1'b1;
  assign tat       = time_new - arr_rd;
  assign q_eff     = (quantum_i == '0) ? TIME_W'(1) : quantum_i;
  assign add_ok    = count_q < CNT_W'(MAX_PROCS);

  assign status_o.hold_usable = held_v_q && rd_ready;
  assign status_o.cand_ready  = rd_ready;
  assign status_o.scan_done   = k_q >= count_q;
  assign status_o.ring_empty  = fill_q == '0;
  assign status_o.requeue     = chosen_v_q && (rem_new != '0) && (pol_i == POL_RR) &&
                                (slice_new >= q_eff);
  assign status_o.out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_ADD && add_ok) begin
      arr_q[count_q[SLOT_W-1:0]] <= arrival_time_i;
      bur_q[count_q[SLOT_W-1:0]] <= burst_time_i;
      rem_q[count_q[SLOT_W-1:0]] <= burst_time_i;
      pri_q[count_q[SLOT_W-1:0]] <= priority_level_i;
    end else if (cmd_i.op == OP_EXEC && chosen_v_q) begin
      rem_q[chosen_q] <= rem_new;
    end
    if (push_ok) begin
      ring_q[tail] <= push_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EXEC) begin
      res_idle_q <= !chosen_v_q;
      res_slot_q <= chosen_v_q ? chosen_q : '0;
      res_fin_q  <= chosen_v_q && (rem_new == '0);
      if (chosen_v_q && rem_new == '0) begin
        res_comp_q <= time_new;
        res_tat_q  <= tat;
        res_wait_q <= tat - bur_rd;
      end else begin
        res_comp_q <= '0;
        res_tat_q  <= '0;
        res_wait_q <= '0;
      end
    end
    if (cmd_i.op == OP_OUT) begin
      out_idle_q <= res_idle_q;
      out_fin_q  <= res_fin_q;
      out_slot_q <= res_slot_q;
      out_comp_q <= res_comp_q;
      out_tat_q  <= res_tat_q;
      out_wait_q <= res_wait_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      time_q      <= '0;
      held_q      <= '0;
      held_v_q    <= 1'b0;
      slice_q     <= '0;
      head_q      <= '0;
      fill_q      <= '0;
      admitted_q  <= '0;
      inring_q    <= '0;
      k_q         <= '0;
      found_q     <= 1'b0;
      best_q      <= '0;
      best_key_q  <= '0;
      cand_q      <= '0;
      chosen_q    <= '0;
      chosen_v_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (push_ok) begin
        fill_q                <= fill_q + 1'b1;
        inring_q[push_slot]   <= 1'b1;
        admitted_q[push_slot] <= 1'b1;
      end
      case (cmd_i.op)
        OP_ADD: begin
          if (add_ok) begin
            admitted_q[count_q[SLOT_W-1:0]] <= 1'b0;
            count_q                         <= count_q + 1'b1;
          end
        end
        OP_CLEAR: begin
          count_q    <= '0;
          time_q     <= '0;
          held_q     <= '0;
          held_v_q   <= 1'b0;
          slice_q    <= '0;
          head_q     <= '0;
          fill_q     <= '0;
          admitted_q <= '0;
          inring_q   <= '0;
        end
        OP_TICK_START: begin
          chosen_v_q <= 1'b0;
        end
        OP_TAKE_HOLD: begin
          chosen_q   <= held_q;
          chosen_v_q <= 1'b1;
        end
        OP_SCAN_START: begin
          k_q     <= '0;
          found_q <= 1'b0;
          if (cmd_i.drop_hold) begin
            held_v_q <= 1'b0;
          end
        end
        OP_SCAN_STEP: begin
          k_q <= k_q + 1'b1;
          if (!cmd_i.admit && better) begin
            found_q    <= 1'b1;
            best_q     <= rd_addr;
            best_key_q <= key;
          end
        end
        OP_TAKE_BEST: begin
          chosen_q   <= best_q;
          chosen_v_q <= found_q;
          if (pol_i == POL_FCFS_ARR || pol_i == POL_PRIO_NON || pol_i == POL_SJF) begin
            held_v_q <= found_q;
            if (found_q) begin
              held_q  <= best_q;
              slice_q <= '0;
            end
          end
        end
        OP_POP: begin
          cand_q           <= ring_q[head_q];
          inring_q[ring_q[head_q]] <= 1'b0;
          head_q           <= head_next;
          fill_q           <= fill_q - 1'b1;
        end
        OP_CAND_CHK: begin
          if (rd_ready) begin
            chosen_q   <= cand_q;
            chosen_v_q <= 1'b1;
            held_q     <= cand_q;
            held_v_q   <= 1'b1;
            slice_q    <= '0;
          end
        end
        OP_EXEC: begin
          time_q <= time_new;
          k_q    <= '0;
          if (chosen_v_q) begin
            slice_q <= slice_new;
            if (rem_new == '0 && held_v_q && held_q == chosen_q) begin
              held_v_q <= 1'b0;
            end
          end
        end
        OP_REQUEUE: begin
          held_v_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid_o       = out_valid_q;
  assign running_slot_o    = out_slot_q;
  assign idle_o            = out_idle_q;
  assign finished_o        = out_fin_q;
  assign completion_time_o = out_comp_q;
  assign turnaround_o      = out_tat_q;
  assign waiting_o         = out_wait_q;

endmodule

/* rtl/mpts_ctrl.sv */
module mpts_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mpts_pkg::KIND_W-1:0]  kind_i,
  input  logic [mpts_pkg::POL_W-1:0]   pol_i,
  input  mpts_pkg::dp_status_t         status_i,
  output mpts_pkg::dp_cmd_t            cmd_o
);
  import mpts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TICK,
    S_PICK,
    S_ADMIT,
    S_POP,
    S_CAND,
    S_EXEC,
    S_RQ_ADMIT,
    S_OUT
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   non_pre;

  assign non_pre    = (pol_i == POL_FCFS_ARR) || (pol_i == POL_PRIO_NON) || (pol_i == POL_SJF);
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d         = state_q;
    cmd_o.op        = OP_NONE;
    cmd_o.admit     = 1'b0;
    cmd_o.drop_hold = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            KIND_ADD:   cmd_o.op = OP_ADD;
            KIND_CLEAR: cmd_o.op = OP_CLEAR;
            KIND_TICK: begin
              cmd_o.op = OP_TICK_START;
              state_d  = S_TICK;
            end
            default:    cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_TICK: begin
        if ((pol_i == POL_RR || non_pre) && status_i.hold_usable) begin
          cmd_o.op = OP_TAKE_HOLD;
          state_d  = S_EXEC;
        end else if (pol_i == POL_RR) begin
          cmd_o.op        = OP_SCAN_START;
          cmd_o.drop_hold = 1'b1;
          state_d         = S_ADMIT;
        end else begin
          cmd_o.op = OP_SCAN_START;
          state_d  = S_PICK;
        end
      end
      S_PICK: begin
        if (status_i.scan_done) begin
          cmd_o.op = OP_TAKE_BEST;
          state_d  = S_EXEC;
        end else begin
          cmd_o.op = OP_SCAN_STEP;
        end
      end
      S_ADMIT: begin
        if (status_i.scan_done) begin
          state_d = S_POP;
        end else begin
          cmd_o.op    = OP_SCAN_STEP;
          cmd_o.admit = 1'b1;
        end
      end
      S_POP: begin
        if (status_i.ring_empty) begin
          state_d = S_EXEC;
        end else begin
          cmd_o.op = OP_POP;
          state_d  = S_CAND;
        end
      end
      S_CAND: begin
        cmd_o.op = OP_CAND_CHK;
        state_d  = status_i.cand_ready ? S_EXEC : S_POP;
      end
      S_EXEC: begin
        cmd_o.op = OP_EXEC;
        state_d  = status_i.requeue ? S_RQ_ADMIT : S_OUT;
      end
      S_RQ_ADMIT: begin
        if (status_i.scan_done) begin
          cmd_o.op = OP_REQUEUE;
          state_d  = S_OUT;
        end else begin
          cmd_o.op    = OP_SCAN_STEP;
          cmd_o.admit = 1'b1;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/multi_policy_cpu_tick_scheduler.sv */
// Tick scheduler over a table of up to 16 processes.
// Input channel (in_valid_i/in_ready_o): kind_i selects add entry, clear or tick;
// arrival_time_i, burst_time_i and priority_level_i matter for an add only.
// Add and clear give no result; an add to a full table is dropped.
// A tick gives one result on the output channel (out_valid_o/out_ready_i): the slot run
// or idle, plus completion, turnaround and waiting times when the process finishes.
// Scanned policies scan all N table entries before the pick. Round robin replaces
// the pick with an admission pass over the table, pops ring entries until one is
// ready or the ring runs dry, and makes another admission pass when a slice
// expires. A held process skips the scan.
// The scan reads one table entry per cycle through a single comparator.
// One transaction is worked on at a time; the next is taken once the result sits in
// the output register, and a stalled receiver holds the block at its last step.
// APB port: policy at 0x0, quantum at 0x4; pready is always high.
// Reset empties the table, zeroes the clock, sets policy 0 and quantum 1.
module multi_policy_cpu_tick_scheduler (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mpts_pkg::KIND_W-1:0]  kind_i,
  input  logic [mpts_pkg::TIME_W-1:0]  arrival_time_i,
  input  logic [mpts_pkg::TIME_W-1:0]  burst_time_i,
  input  logic [mpts_pkg::PRIO_W-1:0]  priority_level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [mpts_pkg::SLOT_W-1:0]  running_slot_o,
  output logic                         idle_o,
  output logic                         finished_o,
  output logic [mpts_pkg::TIME_W-1:0]  completion_time_o,
  output logic [mpts_pkg::TIME_W-1:0]  turnaround_o,
  output logic [mpts_pkg::TIME_W-1:0]  waiting_o
);
  import mpts_pkg::*;

  logic [POL_W-1:0]  policy_q;
  logic [TIME_W-1:0] quantum_q;
  logic [POL_W-1:0]  pol_eff;
  logic              wr_en;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign pol_eff = (policy_q == POL_UNUSED) ? POL_FCFS_SLOT : policy_q;
  assign prdata  = (paddr[2] == REG_QUANTUM) ? {16'd0, quantum_q} : {29'd0, policy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q  <= POL_FCFS_SLOT;
      quantum_q <= TIME_W'(1);
    end else if (wr_en) begin
      if (paddr[2] == REG_QUANTUM) begin
        quantum_q <= pwdata[TIME_W-1:0];
      end else begin
        policy_q <= pwdata[POL_W-1:0];
      end
    end
  end

  mpts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .kind_i     (kind_i),
    .pol_i      (pol_eff),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpts_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .pol_i             (pol_eff),
    .quantum_i         (quantum_q),
    .arrival_time_i    (arrival_time_i),
    .burst_time_i      (burst_time_i),
    .priority_level_i  (priority_level_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .running_slot_o    (running_slot_o),
    .idle_o            (idle_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .waiting_o         (waiting_o)
  );

endmodule

/* dv/tb_multi_policy_cpu_tick_scheduler.sv */
module tb_multi_policy_cpu_tick_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import mpts_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;
  localparam logic [2:0] ADDR_POLICY  = 3'd0;
  localparam logic [2:0] ADDR_QUANTUM = 3'd4;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } job_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } tick_rpt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [TIME_W-1:0] arrival_time_i = '0;
  logic [TIME_W-1:0] burst_time_i = '0;
  logic [PRIO_W-1:0] priority_level_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [SLOT_W-1:0] running_slot_o;
  logic idle_o, finished_o;
  logic [TIME_W-1:0] completion_time_o, turnaround_o, waiting_o;

  multi_policy_cpu_tick_scheduler dut (.*);

  // scheduler shadow state
  logic [2:0]        sh_policy = POL_FCFS_SLOT;
  logic [15:0]       sh_quantum = 16'd1;
  logic [15:0]       sh_arr [MAX_PROCS];
  logic [15:0]       sh_burst [MAX_PROCS];
  logic [15:0]       sh_rem [MAX_PROCS];
  logic [7:0]        sh_prio [MAX_PROCS];
  int                sh_count = 0;
  logic [15:0]       sh_now = '0;
  int                sh_held = 0;
  bit                sh_held_v = 0;
  logic [15:0]       sh_slice = '0;
  int                sh_ring [MAX_PROCS];
  int                sh_head = 0;
  int                sh_fill = 0;
  bit                sh_adm [MAX_PROCS];

  job_t      pending_jobs[$];
  tick_rpt_t expected_ticks[$];
  int        errors = 0;
  int        ticks_seen = 0;
  int        finishes_seen = 0;
  int        stall_pct = 0;
  int        gap_pct = 0;
  bit        long_stall = 0;
  bit        hold_sender = 0;
  int        quiet_cycles = 0;

  function automatic void append_job(job_t j);
    pending_jobs = {pending_jobs, j};
  endfunction

  function automatic bit proc_ready(int k);
    return k < sh_count && sh_arr[k] <= sh_now && sh_rem[k] != 0;
  endfunction

  function automatic logic [15:0] sel_key(logic [2:0] pol, int k);
    case (pol)
      POL_FCFS_ARR: return sh_arr[k];
      POL_PRIO_PRE, POL_PRIO_NON: return {8'd0, sh_prio[k]};
      POL_SJF: return sh_burst[k];
      POL_SRTF: return sh_rem[k];
      default: return 16'd0;
    endcase
  endfunction

  function automatic int best_slot(logic [2:0] pol);
    int best;
    logic [15:0] bk;
    best = -1;
    bk = '0;
    for (int k = 0; k < sh_count; k++) begin
      if (proc_ready(k) && (best < 0 || sel_key(pol, k) < bk)) begin
        best = k;
        bk = sel_key(pol, k);
      end
    end
    return best;
  endfunction

  function automatic void ring_enqueue(int s);
    if (sh_fill >= MAX_PROCS) return;
    for (int i = 0; i < sh_fill; i++)
      if (sh_ring[(sh_head + i) % MAX_PROCS] == s) return;
    sh_ring[(sh_head + sh_fill) % MAX_PROCS] = s;
    sh_fill++;
    sh_adm[s] = 1;
  endfunction

  function automatic void admit_new();
    for (int k = 0; k < sh_count; k++) begin
      if (sh_adm[k] || !proc_ready(k)) continue;
      if (sh_held_v && sh_held == k) continue;
      ring_enqueue(k);
    end
  endfunction

  function automatic void schedule_job(job_t j);
    logic [2:0] pol;
    logic [15:0] q;
    logic [15:0] tat;
    int chosen;
    tick_rpt_t r;
    pol = (sh_policy == POL_UNUSED) ? POL_FCFS_SLOT : sh_policy;
    q = (sh_quantum == 0) ? 16'd1 : sh_quantum;
    chosen = -1;
    r = '0;
    if (j.kind == KIND_ADD) begin
      if (sh_count < MAX_PROCS) begin
        sh_arr[sh_count] = j.arrival;
        sh_burst[sh_count] = j.burst;
        sh_rem[sh_count] = j.burst;
        sh_prio[sh_count] = j.prio;
        sh_adm[sh_count] = 0;
        sh_count++;
      end
      return;
    end
    if (j.kind == KIND_CLEAR) begin
      sh_count = 0; sh_now = 0; sh_held = 0; sh_held_v = 0; sh_slice = 0;
      sh_head = 0; sh_fill = 0;
      for (int k = 0; k < MAX_PROCS; k++) sh_adm[k] = 0;
      return;
    end
    if (j.kind != KIND_TICK) return;
    if (pol == POL_RR) begin
      if (sh_held_v && proc_ready(sh_held)) chosen = sh_held;
      else begin
        sh_held_v = 0;
        admit_new();
        while (sh_fill > 0 && chosen < 0) begin
          int s;
          s = sh_ring[sh_head];
          sh_head = (sh_head + 1) % MAX_PROCS;
          sh_fill--;
          if (proc_ready(s)) chosen = s;
        end
        if (chosen >= 0) begin
          sh_held = chosen; sh_held_v = 1; sh_slice = 0;
        end
      end
    end else if (pol == POL_FCFS_ARR || pol == POL_PRIO_NON || pol == POL_SJF) begin
      if (sh_held_v && proc_ready(sh_held)) chosen = sh_held;
      else begin
        chosen = best_slot(pol);
        sh_held_v = chosen >= 0;
        if (chosen >= 0) begin
          sh_held = chosen; sh_slice = 0;
        end
      end
    end else chosen = best_slot(pol);
    if (chosen < 0) begin
      sh_now++;
      r.idle = 1'b1;
    end else begin
      sh_rem[chosen]--;
      if (sh_slice != 16'hFFFF) sh_slice++;
      sh_now++;
      r.slot = chosen[3:0];
      if (sh_rem[chosen] == 0) begin
        tat = sh_now - sh_arr[chosen];
        r.finished = 1'b1;
        r.completion = sh_now;
        r.turnaround = tat;
        r.waiting = tat - sh_burst[chosen];
        if (sh_held_v && sh_held == chosen) sh_held_v = 0;
      end else if (pol == POL_RR && sh_slice >= q) begin
        admit_new();
        sh_held_v = 0;
        ring_enqueue(chosen);
      end
    end
    expected_ticks = {expected_ticks, r};
  endfunction

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i) begin
    job_t j;
    if (in_valid_i && in_ready_o) begin
      schedule_job(pending_jobs.pop_front());
    end
    if (!(in_valid_i && !in_ready_o)) begin
      if (pending_jobs.size() > 0 && !hold_sender && $urandom_range(99) >= gap_pct) begin
        j = pending_jobs[0];
        in_valid_i <= 1'b1;
        kind_i <= j.kind;
        arrival_time_i <= j.arrival;
        burst_time_i <= j.burst;
        priority_level_i <= j.prio;
      end else in_valid_i <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    tick_rpt_t got, exp;
    if (out_valid_o && out_ready_i) begin
      got = '{running_slot_o, idle_o, finished_o, completion_time_o, turnaround_o, waiting_o};
      ticks_seen++;
      if (finished_o) finishes_seen++;
      if (expected_ticks.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        exp = expected_ticks.pop_front();
        if (got !== exp) begin
          errors++;
          $display("%0t: mismatch expected %p actual %p", $time, exp, got);
        end
      end
    end
    out_ready_i <= !long_stall && ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || long_stall || psel)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data; penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_POLICY) sh_policy = data[2:0];
    else sh_quantum = data[15:0];
  endtask

  task automatic drain();
    while (pending_jobs.size() > 0 || in_valid_i || expected_ticks.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  function automatic job_t mk(logic [1:0] k, int a, int b, int p);
    job_t j;
    j.kind = k; j.arrival = 16'(a); j.burst = 16'(b); j.prio = 8'(p);
    return j;
  endfunction

  // a cleared table, n_proc processes (small unless wide), then 4 to 18 jobs, mostly ticks
  task automatic queue_workload(int n_proc, bit wide);
    int n_ticks;
    n_ticks = 0;
    append_job(mk(KIND_CLEAR, $urandom, $urandom, $urandom));
    for (int i = 0; i < n_proc; i++) begin
      append_job(mk(KIND_ADD, wide ? $urandom : $urandom_range(0, 8),
                    wide ? $urandom : $urandom_range(0, 5), $urandom));
      if ($urandom_range(5) == 0) append_job(mk(KIND_TICK, 0, 0, 0));
    end
    n_ticks = $urandom_range(4, 18);
    for (int i = 0; i < n_ticks; i++) begin
      case ($urandom_range(30))
        0: append_job(mk(KIND_UNUSED, $urandom, $urandom, $urandom));
        1: append_job(mk(KIND_ADD, $urandom_range(0, 20),
                         $urandom_range(1, 4), $urandom));
        default: append_job(mk(KIND_TICK, $urandom, $urandom, $urandom));
      endcase
    end
  endtask

  initial begin
    logic [2:0] pols [8];
    logic [15:0] qs [8];
    pols = '{POL_FCFS_SLOT, POL_FCFS_ARR, POL_PRIO_PRE, POL_PRIO_NON,
             POL_RR, POL_SJF, POL_SRTF, POL_UNUSED};
    qs = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd65535, 16'd1, 16'd4, 16'd7};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: full table, dropped add, zero burst, extremes, tick, add and the unused kind
    append_job(mk(KIND_TICK, 0, 0, 0));
    append_job(mk(KIND_ADD, 16'hFFFF, 16'hFFFF, 8'hFF));
    append_job(mk(KIND_ADD, 0, 0, 0));
    append_job(mk(KIND_ADD, 0, 1, 8'h00));
    for (int i = 0; i < 14; i++)
      append_job(mk(KIND_ADD, i, 2, 8'hA5 ^ i));
    append_job(mk(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF));
    for (int i = 0; i < 6; i++) append_job(mk(KIND_TICK, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 32; ph++) begin
      apb_write(ADDR_POLICY, {29'd0, pols[ph % 8]});
      apb_write(ADDR_QUANTUM, {16'd0, qs[(ph / 8 + ph) % 8]});
      case ((ph / 2) % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 49; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 49; end
        default: begin gap_pct = 31; stall_pct = 31; end
      endcase
      for (int w = 0; w < 2; w++)
        queue_workload($urandom_range(1, 16), ($urandom_range(9) == 0));
      if (ph == 5) begin
        long_stall = 1;
        repeat (400) @(posedge clk_i);
        long_stall = 0;
      end
      if (ph == 9) begin
        while (pending_jobs.size() > 20) @(posedge clk_i);
        hold_sender = 1;
        while (expected_ticks.size() > 0 || in_valid_i) @(posedge clk_i);
        hold_sender = 0;
      end
      drain();
    end
    // the time wrap: a long process runs past 65535 only with many ticks, so arrivals
    // near the top end are checked above instead
    $display("Checked %0d tick results (%0d completions) over all policies and quanta,",
             ticks_seen, finishes_seen);
    $display("with sender gaps, receiver stalls, a long output stall and a full drain.");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
